### hdl/axis_direction_hysteresis_latch_assert.svh
// Assertion macros shared by the checker of the axis direction latch.
`ifndef AXIS_DIRECTION_HYSTERESIS_LATCH_ASSERT_SVH
`define AXIS_DIRECTION_HYSTERESIS_LATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADHL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("axis direction latch check failed");

// The consequent must hold in the cycle after the antecedent.
`define ADHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("axis direction latch check failed");

`endif

### hdl/adhl_pkg.sv
package adhl_pkg;

   localparam int PADS = 4;
   localparam int AXES = 4;
   localparam int SLOTS = PADS * AXES * 2;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Range limits, wide enough to hold the largest legal count.
   localparam logic [4:0] PAD_LIMIT = 5'(PADS);
   localparam logic [4:0] AXIS_LIMIT = 5'(AXES);

   localparam logic [7:0]  BOUND_MASK_RESET = 8'd0;
   localparam logic [14:0] DEADZONE_RESET = 15'd4915;
   localparam logic [15:0] RELEASE_FACTOR_RESET = 16'd32768;

   // Full scale in Q1.15 and the saturated strength.
   localparam logic [15:0] FULL_SCALE = 16'd32768;
   localparam logic [15:0] STRENGTH_MAX = 16'hFFFF;
   localparam logic [3:0]  DIV_LAST_STEP = 4'd15;

   typedef enum logic [1:0] {
      CSR_BOUND_MASK     = 2'd0,
      CSR_DEADZONE       = 2'd1,
      CSR_RELEASE_FACTOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         pad_index;
      logic [1:0]         axis_index;
      logic signed [15:0] axis_value;
   } adhl_req_type;

   typedef struct packed {
      logic [1:0]  event_pad;
      logic [1:0]  event_axis;
      logic        direction;
      logic        pressed;
      logic [15:0] strength;
      logic        last;
   } adhl_rsp_type;

endpackage

### hdl/axis_direction_hysteresis_latch.sv
// Axis direction hysteresis latch. Each request is one stick sample (pad,
// axis, signed Q1.15 deflection). The block keeps a press latch for every
// pad, axis and direction, handles the negative direction and then the
// positive one, and emits up to two events per sample on the response
// channel, the final one flagged by last. A released latch presses when the
// deflection magnitude reaches the deadzone; a held latch releases once the
// magnitude drops below deadzone times release_factor. A down event carries
// the strength (m - deadzone) / (1 - deadzone) in Q0.16, saturated. A
// direction whose bit in bound_mask is clear has its latch cleared without
// an event, and a sample from a pad or axis beyond the configured count is
// dropped. Timing: after a request is accepted, req_ready stays low while the
// block forms the release threshold, evaluates each direction and sends
// each pending event, so no new sample is taken before the block is through
// with the last one. A down event below full deflection takes its strength
// from one restoring divider that produces one quotient bit per cycle; a
// down event at full deflection saturates without the divider. A stalled
// response channel adds its wait on top. Configuration registers are
// written through the csr port at any time the block is idle.
module axis_direction_hysteresis_latch
   import adhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  adhl_req_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output adhl_rsp_type  rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data
);

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PROD  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_SEND0 = 6'b010000,
      ST_SEND1 = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0]  bound_mask_ff, bound_mask_in;
   logic [14:0] deadzone_ff, deadzone_in;
   logic [15:0] release_factor_ff, release_factor_in;

   // One press latch per pad, axis and direction.
   logic [SLOTS-1:0] latch_ff, latch_in;

   // The sample being worked on.
   adhl_req_type sample_ff, sample_in;
   logic         dir_ff, dir_in;

   // Release threshold, deadzone times release_factor.
   logic [30:0] thresh_ff, thresh_in;

   // Divider state.
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] divisor_ff, divisor_in;
   logic [3:0]  step_ff, step_in;

   // Pending events, one per direction.
   logic [1:0]  ev_ff, ev_in;
   logic [1:0]  ev_pressed_ff, ev_pressed_in;
   logic [15:0] ev_strength_ff [2];
   logic [15:0] ev_strength_in [2];

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   adhl_rsp_type rsp_data_ff, rsp_data_in;

   // Evaluation of the current direction.
   logic [SLOT_W-1:0] slot;
   logic              bound;
   logic              was;
   logic              now;
   logic [15:0]       mag;
   logic [15:0]       excess;
   logic [15:0]       span;
   logic [16:0]       rem_shift;
   logic              rem_ge;
   logic              out_free;
   logic              in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_range = ({3'b000, req_data.pad_index} < PAD_LIMIT) &&
                     ({3'b000, req_data.axis_index} < AXIS_LIMIT);

   assign slot = SLOT_W'((int'(sample_ff.pad_index) * AXES +
                          int'(sample_ff.axis_index)) * 2 + int'(dir_ff));
   assign bound = bound_mask_ff[{sample_ff.axis_index, dir_ff}];
   assign was   = latch_ff[slot];

   // Magnitude along the current direction, 0..32768.
   always_comb begin
      mag = 16'd0;
      if (dir_ff) begin
         if (!sample_ff.axis_value[15]) begin
            mag = sample_ff.axis_value;
         end
      end else begin
         if (sample_ff.axis_value[15]) begin
            mag = 16'd0 - sample_ff.axis_value;
         end
      end
   end

   // A held latch stays while m * 65536 reaches the threshold exactly.
   assign now = was ? ({mag, 16'h0000} >= {1'b0, thresh_ff})
                    : (mag >= {1'b0, deadzone_ff});

   assign excess = mag - {1'b0, deadzone_ff};
   assign span   = FULL_SCALE - {1'b0, deadzone_ff};

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      bound_mask_in     = bound_mask_ff;
      deadzone_in       = deadzone_ff;
      release_factor_in = release_factor_ff;
      latch_in          = latch_ff;
      dir_in            = dir_ff;
      ev_in             = ev_ff;
      step_in           = step_ff;
      rsp_valid_in      = rsp_valid_ff;

      sample_in         = sample_ff;
      thresh_in         = thresh_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      divisor_in        = divisor_ff;
      ev_pressed_in     = ev_pressed_ff;
      ev_strength_in    = ev_strength_ff;
      rsp_data_in       = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_BOUND_MASK:     bound_mask_in     = csr_data[7:0];
            CSR_DEADZONE:       deadzone_in       = csr_data[14:0];
            CSR_RELEASE_FACTOR: release_factor_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_data;
               dir_in    = 1'b0;
               ev_in     = 2'b00;
               if (in_range) begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            thresh_in = 31'(deadzone_ff * release_factor_ff);
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = dir_ff ? ST_SEND0 : ST_EVAL;
            dir_in   = 1'b1;
            if (!bound) begin
               latch_in[slot] = 1'b0;
            end else if (now != was) begin
               latch_in[slot]        = now;
               ev_in[dir_ff]         = 1'b1;
               ev_pressed_in[dir_ff] = now;
               ev_strength_in[dir_ff] = 16'd0;
               if (now) begin
                  if (excess >= span) begin
                     // Full reach of the span saturates the strength.
                     ev_strength_in[dir_ff] = STRENGTH_MAX;
                  end else begin
                     rem_in     = excess;
                     quo_in     = 16'd0;
                     divisor_in = span;
                     step_in    = 4'd0;
                     dir_in     = dir_ff;
                     state_in   = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? 16'(rem_shift - {1'b0, divisor_ff}) : rem_shift[15:0];
            quo_in  = {quo_ff[14:0], rem_ge};
            step_in = step_ff + 4'd1;
            if (step_ff == DIV_LAST_STEP) begin
               ev_strength_in[dir_ff] = {quo_ff[14:0], rem_ge};
               dir_in   = 1'b1;
               state_in = dir_ff ? ST_SEND0 : ST_EVAL;
            end
         end
         ST_SEND0: begin
            if (!ev_ff[0]) begin
               state_in = ST_SEND1;
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.event_pad  = sample_ff.pad_index;
               rsp_data_in.event_axis = sample_ff.axis_index;
               rsp_data_in.direction  = 1'b0;
               rsp_data_in.pressed    = ev_pressed_ff[0];
               rsp_data_in.strength   = ev_strength_ff[0];
               rsp_data_in.last       = !ev_ff[1];
               state_in               = ST_SEND1;
            end
         end
         ST_SEND1: begin
            if (!ev_ff[1]) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.event_pad  = sample_ff.pad_index;
               rsp_data_in.event_axis = sample_ff.axis_index;
               rsp_data_in.direction  = 1'b1;
               rsp_data_in.pressed    = ev_pressed_ff[1];
               rsp_data_in.strength   = ev_strength_ff[1];
               rsp_data_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         bound_mask_ff     <= BOUND_MASK_RESET;
         deadzone_ff       <= DEADZONE_RESET;
         release_factor_ff <= RELEASE_FACTOR_RESET;
         latch_ff          <= '0;
         dir_ff            <= 1'b0;
         ev_ff             <= 2'b00;
         step_ff           <= 4'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         bound_mask_ff     <= bound_mask_in;
         deadzone_ff       <= deadzone_in;
         release_factor_ff <= release_factor_in;
         latch_ff          <= latch_in;
         dir_ff            <= dir_in;
         ev_ff             <= ev_in;
         step_ff           <= step_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      thresh_ff      <= thresh_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      divisor_ff     <= divisor_in;
      ev_pressed_ff  <= ev_pressed_in;
      ev_strength_ff <= ev_strength_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

### hdl/adhl_checker.sv
`include "axis_direction_hysteresis_latch_assert.svh"

module adhl_checker
   import adhl_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input adhl_rsp_type rsp_data
);

   // A stalled response keeps its payload.
   `ADHL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // The block works on one sample at a time.
   `ADHL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // An up event carries no strength.
   `ADHL_ASSERT_NOW(a_up_zero, clock, reset, rsp_valid && !rsp_data.pressed, rsp_data.strength == 16'd0)

   // A taken event that is not the last one is followed at once by the next.
   `ADHL_ASSERT_NEXT(a_second_event, clock, reset, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid && rsp_data.last)

endmodule

bind axis_direction_hysteresis_latch adhl_checker u_adhl_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import adhl_pkg::*;

   // The run is cut off here; the slowest legal run stays well below it.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Quiet time after the last expected event. A sample that causes no event
   // can keep the block busy, and two down events both run the divider, so
   // this covers the longest job still in flight.
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int HOLD_CYCLES = 400;

   // Tracks the press latches and the register copies, predicts the events
   // that each accepted sample causes, and compares each event that leaves
   // the block against the oldest prediction.
   class latch_tracker;
      bit           latch_held [SLOTS];
      logic [7:0]   bound;
      logic [14:0]  zone;
      logic [15:0]  release_q;
      adhl_rsp_type due_events [$];
      int           errors;

      function new();
         foreach (latch_held[i]) latch_held[i] = 1'b0;
         bound = BOUND_MASK_RESET;
         zone = DEADZONE_RESET;
         release_q = RELEASE_FACTOR_RESET;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_BOUND_MASK: begin
               bound = value[7:0];
            end
            CSR_DEADZONE: begin
               zone = value[14:0];
            end
            CSR_RELEASE_FACTOR: begin
               release_q = value;
            end
            default: begin
            end
         endcase
      endfunction

      // Deadzone-rescaled deflection in Q0.16, saturated at full scale.
      function logic [15:0] scaled_strength(int unsigned mag);
         longint unsigned num;
         longint unsigned quo;
         if (mag <= zone) return 16'd0;
         num = longint'(mag - zone) << 16;
         quo = num / (32768 - zone);
         return (quo > 65535) ? STRENGTH_MAX : quo[15:0];
      endfunction

      function void note_sample(adhl_req_type s);
         adhl_rsp_type evs [$];
         adhl_rsp_type ev;
         int           v;
         int unsigned  mag;
         int           slot;
         bit           now;
         longint unsigned lhs;
         longint unsigned rhs;
         v = $signed(s.axis_value);
         // Negative direction first, then positive.
         for (int d = 0; d < 2; d++) begin
            slot = (int'(s.pad_index) * AXES + int'(s.axis_index)) * 2 + d;
            if (!bound[int'(s.axis_index) * 2 + d]) begin
               latch_held[slot] = 1'b0;
               continue;
            end
            if (d == 1) mag = (v > 0) ? v : 0;
            else mag = (v < 0) ? -v : 0;
            if (latch_held[slot]) begin
               lhs = mag;
               lhs = lhs << 16;
               rhs = zone;
               rhs = rhs * release_q;
               now = (lhs >= rhs);
            end else begin
               now = (mag >= zone);
            end
            if (now == latch_held[slot]) continue;
            latch_held[slot] = now;
            ev.event_pad = s.pad_index;
            ev.event_axis = s.axis_index;
            ev.direction = d[0];
            ev.pressed = now;
            ev.strength = now ? scaled_strength(mag) : 16'd0;
            ev.last = 1'b0;
            evs.push_back(ev);
         end
         if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
         foreach (evs[i]) due_events.push_back(evs[i]);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check_field(string name, int got, int want);
         if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_event(adhl_rsp_type got);
         adhl_rsp_type want;
         if (due_events.size() == 0) begin
            report($sformatf("unexpected event pad %0d axis %0d dir %0d",
                             got.event_pad, got.event_axis, got.direction));
            return;
         end
         want = due_events.pop_front();
         check_field("event_pad", got.event_pad, want.event_pad);
         check_field("event_axis", got.event_axis, want.event_axis);
         check_field("direction", got.direction, want.direction);
         check_field("pressed", got.pressed, want.pressed);
         check_field("strength", got.strength, want.strength);
         check_field("last", got.last, want.last);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   adhl_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   adhl_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;

   latch_tracker sb;
   int req_gap_max;
   int rsp_gap_max;
   int rsp_hold;
   int cycle_count;
   int sent_in_phase;

   axis_direction_hysteresis_latch i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost event ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // All handshakes are observed at the rising edge, before the nonblocking
   // updates of that edge land, so the monitor sees exactly what the block
   // sampled. Register writes update the tracker's copy in the same place.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index_type'(csr_index), csr_data);
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_event(rsp_data);
      end
   end

   // Receiver. Before each response it draws a wait; when a long hold is
   // requested it keeps ready low through the hold so the block backs up and
   // stops taking requests.
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offers one request after a random gap and returns at the edge where it
   // is accepted. Valid stays high afterwards so that back-to-back requests
   // never see a low/high pair in one step.
   task automatic send_sample(logic [1:0] pad, logic [1:0] ax, logic signed [15:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{pad_index: pad, axis_index: ax, axis_value: value};
      do @(posedge clock); while (!(req_valid && req_ready));
      sent_in_phase++;
   endtask

   // Writes all three registers back to back; only legal while idle.
   task automatic program_regs(logic [7:0] mask, logic [14:0] zone, logic [15:0] factor);
      csr_valid <= 1'b1;
      csr_index <= CSR_BOUND_MASK;
      csr_data <= {8'd0, mask};
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_index <= CSR_DEADZONE;
      csr_data <= {1'b0, zone};
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_index <= CSR_RELEASE_FACTOR;
      csr_data <= factor;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // Stops offering requests and waits until every predicted event is out
   // and the block has had time to finish a sample that emits nothing.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Turns a sign and a magnitude in 0..32768 into a Q1.15 sample.
   function automatic logic signed [15:0] to_value(int sgn, int mag);
      if (mag < 0) mag = 0;
      if (mag > 32768) mag = 32768;
      if (sgn < 0) return 16'(-mag);
      return (mag > 32767) ? 16'sd32767 : 16'(mag);
   endfunction

   // Magnitudes that sit right on the press or release thresholds, at the
   // ends of the range, or anywhere.
   function automatic int pick_magnitude();
      int rel;
      rel = int'((longint'(sb.zone) * sb.release_q) >> 16);
      case ($urandom_range(0, 9)) inside
         [0:1]: return int'(sb.zone) + $urandom_range(0, 4) - 2;
         [2:3]: return rel + $urandom_range(0, 4) - 2;
         4: return 32768 - $urandom_range(0, 2);
         5: return $urandom_range(0, 2);
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   // One stick stroke on a single pad and axis: ramp out to a peak and back
   // to rest, with a little jitter, so latches press, hold and release.
   task automatic run_stroke();
      int pad;
      int ax;
      int n;
      int sgn;
      int peak;
      int mag;
      pad = $urandom_range(0, 3);
      ax = $urandom_range(0, 3);
      n = $urandom_range(2, 6);
      sgn = $urandom_range(0, 1) ? 1 : -1;
      case ($urandom_range(0, 2))
         0: peak = int'(sb.zone) + $urandom_range(0, 64);
         1: peak = 32768;
         default: peak = $urandom_range(0, 32768);
      endcase
      for (int k = 1; k <= 2 * n; k++) begin
         mag = (k <= n) ? peak * k / n : peak * (2 * n - k) / n;
         if (k != 2 * n) mag = mag + $urandom_range(0, 8) - 4;
         send_sample(pad, ax, to_value(sgn, mag));
      end
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BOUND_MASK;
      csr_data <= '0;
      req_gap_max = 16;
      rsp_gap_max = 16;
      rsp_hold = 0;
      sent_in_phase = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With the reset thresholds the release point sits at
      // a magnitude of 2457.5, so 2458 holds and 2457 lets go.
      program_regs(8'hFF, DEADZONE_RESET, RELEASE_FACTOR_RESET);
      send_sample(2'd0, 2'd0, 16'sd0);
      send_sample(2'd0, 2'd0, 16'sd4914);
      send_sample(2'd0, 2'd0, 16'sd4915);
      send_sample(2'd0, 2'd0, 16'sd2458);
      send_sample(2'd0, 2'd0, 16'sd2457);
      send_sample(2'd0, 2'd0, 16'sd32767);
      // Full negative deflection: positive releases, negative presses at
      // saturated strength, two events in one sample.
      send_sample(2'd0, 2'd0, -16'sd32768);
      send_sample(2'd0, 2'd0, -16'sd1);
      send_sample(2'd3, 2'd3, 16'sd32767);
      send_sample(2'd3, 2'd3, -16'sd32768);
      send_sample(2'd2, 2'd1, -16'sd4915);
      send_sample(2'd2, 2'd1, 16'sd4915);
      settle();

      // Only negative directions bound: the positive push is silent.
      program_regs(8'h55, DEADZONE_RESET, RELEASE_FACTOR_RESET);
      send_sample(2'd1, 2'd2, 16'sd32767);
      send_sample(2'd1, 2'd2, -16'sd32768);
      settle();

      // Nothing bound: the held negative latch is cleared without an event.
      program_regs(8'h00, DEADZONE_RESET, RELEASE_FACTOR_RESET);
      send_sample(2'd1, 2'd2, 16'sd0);
      settle();

      // Zero deadzone and zero release factor: everything presses, even at
      // rest, and nothing ever releases.
      program_regs(8'hFF, 15'd0, 16'd0);
      send_sample(2'd1, 2'd2, -16'sd32768);
      send_sample(2'd1, 2'd2, 16'sd0);
      send_sample(2'd0, 2'd1, 16'sd0);
      settle();

      // Largest deadzone and release factor: only the very ends press, and
      // full scale saturates the strength.
      program_regs(8'hFF, 15'h7FFF, 16'hFFFF);
      send_sample(2'd3, 2'd0, 16'sd32767);
      send_sample(2'd3, 2'd0, -16'sd32768);
      send_sample(2'd3, 2'd0, -16'sd32767);
      send_sample(2'd3, 2'd0, 16'sd0);
      settle();

      // Random part, phase by phase with a fresh register setting each time.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: program_regs(8'hFF, DEADZONE_RESET, RELEASE_FACTOR_RESET);
            2: program_regs(8'hFF, 15'h7FFF, 16'hFFFF);
            3: program_regs(8'hFF, 15'($urandom_range(0, 200)), 16'hFFFF);
            4: program_regs(8'($urandom), 15'($urandom), 16'd0);
            5: program_regs(8'hFF, 15'($urandom), 16'($urandom));
            default: program_regs(8'($urandom), 15'($urandom), 16'($urandom));
         endcase
         // Vary heavy idling and none on each side: requests alternate, responses idle none every third phase.
         req_gap_max = (ph % 2 == 1) ? 0 : 16;
         rsp_gap_max = (ph % 3 == 1) ? 0 : 16;
         // One phase starts with the receiver holding off for a long time
         // while requests keep coming.
         if (ph == 5) rsp_hold = HOLD_CYCLES;
         sent_in_phase = 0;
         while (sent_in_phase < ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 9)) inside
               [0:5]: run_stroke();
               [6:7]: send_sample(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                  to_value($urandom_range(0, 1) ? 1 : -1, pick_magnitude()));
               default: send_sample(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                    16'($urandom));
            endcase
         end
         settle();
      end

      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
